### design/qtm_pkg.sv
// ----------------------------------------------------------------------------
// qtm_pkg: shared types and constants for the quaternion transform unit
// Payload structs, queue entry layout, fixed-point widths and group codes.
// ----------------------------------------------------------------------------
package qtm_pkg;

    localparam int Q_W       = 16;  // quaternion and scale width
    localparam int POS_W     = 32;  // Q16.16 position
    localparam int WORD_W    = 32;  // Q16.16 matrix word
    localparam int PROD_W    = 32;  // Q1.14 * Q1.14 product, Q.28
    localparam int BASIS_W   = 35;  // 1 - 2(b+c) and 2(p+-q), Q.28
    localparam int DROP      = 20;  // Q.36 -> Q.16
    localparam int RAW_W     = 54;  // scaled basis, Q.36, with headroom
    localparam int ONE_SHIFT = 28;
    localparam int QDEPTH_DEF = 4;

    localparam logic signed [BASIS_W-1:0] ONE_Q28 = BASIS_W'(1) << ONE_SHIFT;
    localparam logic signed [WORD_W-1:0]  ONE_Q16 = WORD_W'(1) << (WORD_W / 2);
    localparam logic signed [WORD_W-1:0]  WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0]  WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        GRP_X   = 2'd0,
        GRP_Y   = 2'd1,
        GRP_Z   = 2'd2,
        GRP_POS = 2'd3
    } t_grp;

    typedef struct packed {
        logic signed [Q_W-1:0]   quat_x;
        logic signed [Q_W-1:0]   quat_y;
        logic signed [Q_W-1:0]   quat_z;
        logic signed [Q_W-1:0]   quat_w;
        logic signed [Q_W-1:0]   scale_x;
        logic signed [Q_W-1:0]   scale_y;
        logic signed [Q_W-1:0]   scale_z;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_qtm_in;

    typedef struct packed {
        logic [1:0]               group_index;
        logic signed [WORD_W-1:0] word0;
        logic signed [WORD_W-1:0] word1;
        logic signed [WORD_W-1:0] word2;
        logic signed [WORD_W-1:0] word3;
        logic                     last;
        logic                     saturated;
    } t_qtm_out;

    // basis terms named by matrix word position
    typedef struct packed {
        logic signed [BASIS_W-1:0] m0;
        logic signed [BASIS_W-1:0] m1;
        logic signed [BASIS_W-1:0] m2;
        logic signed [BASIS_W-1:0] m4;
        logic signed [BASIS_W-1:0] m5;
        logic signed [BASIS_W-1:0] m6;
        logic signed [BASIS_W-1:0] m8;
        logic signed [BASIS_W-1:0] m9;
        logic signed [BASIS_W-1:0] m10;
        logic signed [Q_W-1:0]     scale_x;
        logic signed [Q_W-1:0]     scale_y;
        logic signed [Q_W-1:0]     scale_z;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
    } t_fq_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fq_status;

endpackage

### design/qtm_front.sv
// ----------------------------------------------------------------------------
// qtm_front: input stage of the quaternion transform unit
// Registers the nine pairwise products, then forms the basis terms and
// pushes them with scale and position into the work queue.
// ----------------------------------------------------------------------------
module qtm_front import qtm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_qtm_in    i_data,
    output logic       o_ready,
    input  logic       i_fq_full,
    output logic       o_wr_en,
    output t_fq_entry  o_wr_data
);

    logic                     r_s1_vld, n_s1_vld;
    logic signed [PROD_W-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [Q_W-1:0]    r_sx, r_sy, r_sz;
    logic signed [POS_W-1:0]  r_px, r_py, r_pz;

    logic signed [PROD_W-1:0] qx, qy, qz, qw;
    logic                     accept;

    assign o_ready = !r_s1_vld || !i_fq_full;
    assign accept  = i_valid && o_ready;
    assign o_wr_en = r_s1_vld && !i_fq_full;

    assign qx = PROD_W'(i_data.quat_x);
    assign qy = PROD_W'(i_data.quat_y);
    assign qz = PROD_W'(i_data.quat_z);
    assign qw = PROD_W'(i_data.quat_w);

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (accept) begin
            n_s1_vld = 1'b1;
        end else if (o_wr_en) begin
            n_s1_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
        end
    end

    // products are exact in 32 bits: |q| <= 2^15, so |q*q| <= 2^30
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_xx <= qx * qx;
            r_yy <= qy * qy;
            r_zz <= qz * qz;
            r_xy <= qx * qy;
            r_xz <= qx * qz;
            r_yz <= qy * qz;
            r_wx <= qw * qx;
            r_wy <= qw * qy;
            r_wz <= qw * qz;
            r_sx <= i_data.scale_x;
            r_sy <= i_data.scale_y;
            r_sz <= i_data.scale_z;
            r_px <= i_data.pos_x;
            r_py <= i_data.pos_y;
            r_pz <= i_data.pos_z;
        end
    end

    always_comb begin
        o_wr_data.m0  = ONE_Q28 - ((BASIS_W'(r_yy) + BASIS_W'(r_zz)) <<< 1);
        o_wr_data.m1  = (BASIS_W'(r_xy) + BASIS_W'(r_wz)) <<< 1;
        o_wr_data.m2  = (BASIS_W'(r_xz) - BASIS_W'(r_wy)) <<< 1;
        o_wr_data.m4  = (BASIS_W'(r_xy) - BASIS_W'(r_wz)) <<< 1;
        o_wr_data.m5  = ONE_Q28 - ((BASIS_W'(r_xx) + BASIS_W'(r_zz)) <<< 1);
        o_wr_data.m6  = (BASIS_W'(r_yz) + BASIS_W'(r_wx)) <<< 1;
        o_wr_data.m8  = (BASIS_W'(r_xz) + BASIS_W'(r_wy)) <<< 1;
        o_wr_data.m9  = (BASIS_W'(r_yz) - BASIS_W'(r_wx)) <<< 1;
        o_wr_data.m10 = ONE_Q28 - ((BASIS_W'(r_xx) + BASIS_W'(r_yy)) <<< 1);
        o_wr_data.scale_x = r_sx;
        o_wr_data.scale_y = r_sy;
        o_wr_data.scale_z = r_sz;
        o_wr_data.pos_x   = r_px;
        o_wr_data.pos_y   = r_py;
        o_wr_data.pos_z   = r_pz;
    end

endmodule

### design/qtm_fifo.sv
// ----------------------------------------------------------------------------
// qtm_fifo: work queue between front and back of the transform unit
// Small register-file FIFO; head entry is visible without a read cycle.
// ----------------------------------------------------------------------------
module qtm_fifo import qtm_pkg::*; #(
    parameter int DEPTH = QDEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr_en,
    input  t_fq_entry  i_wr_data,
    input  logic       i_rd_en,
    output t_fq_entry  o_rd_data,
    output t_fq_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_fq_entry          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr_en && !i_rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr_en && i_rd_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data      = r_mem[r_rd_ptr];
    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

### design/qtm_back.sv
// ----------------------------------------------------------------------------
// qtm_back: output sequencer of the quaternion transform unit
// Walks the four groups of the head entry; scales three basis terms in each
// rotation group (position is pre-shifted), then shifts, clips, registers.
// ----------------------------------------------------------------------------
module qtm_back import qtm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fq_entry  i_rd_data,
    input  t_fq_status i_fq_status,
    output logic       o_rd_en,
    output logic       o_valid,
    input  logic       i_ready,
    output t_qtm_out   o_data
);

    localparam int HI_W = RAW_W - DROP - WORD_W + 1;  // bits that must agree

    t_grp                    r_grp, n_grp;
    logic                    r_a_vld, n_a_vld;
    t_grp                    r_a_grp;
    logic signed [RAW_W-1:0] r_a_raw [3];
    logic                    r_o_vld, n_o_vld;
    t_qtm_out                r_o_data;

    logic                      out_load, a_adv, issue;
    logic signed [BASIS_W-1:0] sel_b [3];
    logic signed [Q_W-1:0]     sel_sc;
    logic signed [RAW_W-1:0]   n_raw [3];
    logic signed [WORD_W-1:0]  clip_w [3];
    logic [2:0]                clip_f;

    assign out_load = !r_o_vld || i_ready;
    assign a_adv    = !r_a_vld || out_load;
    assign issue    = a_adv && !i_fq_status.empty;
    assign o_rd_en  = issue && (r_grp == GRP_POS);

    // group select
    always_comb begin
        unique case (r_grp)
            GRP_X: begin
                sel_b[0] = i_rd_data.m0;
                sel_b[1] = i_rd_data.m1;
                sel_b[2] = i_rd_data.m2;
                sel_sc   = i_rd_data.scale_x;
            end
            GRP_Y: begin
                sel_b[0] = i_rd_data.m4;
                sel_b[1] = i_rd_data.m5;
                sel_b[2] = i_rd_data.m6;
                sel_sc   = i_rd_data.scale_y;
            end
            GRP_Z: begin
                sel_b[0] = i_rd_data.m8;
                sel_b[1] = i_rd_data.m9;
                sel_b[2] = i_rd_data.m10;
                sel_sc   = i_rd_data.scale_z;
            end
            default: begin
                sel_b[0] = '0;
                sel_b[1] = '0;
                sel_b[2] = '0;
                sel_sc   = '0;
            end
        endcase
    end

    // position words ride the same path pre-shifted, so they never clip
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_raw[k] = RAW_W'(sel_b[k]) * RAW_W'(sel_sc);
        end
        if (r_grp == GRP_POS) begin
            n_raw[0] = RAW_W'(i_rd_data.pos_x) <<< DROP;
            n_raw[1] = RAW_W'(i_rd_data.pos_y) <<< DROP;
            n_raw[2] = RAW_W'(i_rd_data.pos_z) <<< DROP;
        end
    end

    always_comb begin
        n_grp   = r_grp;
        n_a_vld = r_a_vld;
        n_o_vld = r_o_vld;
        if (issue) begin
            n_grp = t_grp'(r_grp + 2'd1);
        end
        if (a_adv) begin
            n_a_vld = issue;
        end
        if (out_load) begin
            n_o_vld = r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp   <= GRP_X;
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_grp   <= n_grp;
            r_a_vld <= n_a_vld;
            r_o_vld <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_grp <= r_grp;
            for (int k = 0; k < 3; k++) begin
                r_a_raw[k] <= n_raw[k];
            end
        end
    end

    // floor shift by DROP is a plain slice; clip when upper bits disagree
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [HI_W-1:0] hi;
            hi = r_a_raw[k][RAW_W-1 -: HI_W];
            clip_f[k] = !((hi == '0) || (hi == '1));
            if (!clip_f[k]) begin
                clip_w[k] = r_a_raw[k][DROP +: WORD_W];
            end else if (r_a_raw[k][RAW_W-1]) begin
                clip_w[k] = WORD_MIN;
            end else begin
                clip_w[k] = WORD_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_a_vld) begin
            r_o_data.group_index <= 2'(r_a_grp);
            r_o_data.word0       <= clip_w[0];
            r_o_data.word1       <= clip_w[1];
            r_o_data.word2       <= clip_w[2];
            r_o_data.word3       <= (r_a_grp == GRP_POS) ? ONE_Q16 : '0;
            r_o_data.last        <= (r_a_grp == GRP_POS);
            r_o_data.saturated   <= |clip_f;
        end
    end

    assign o_valid = r_o_vld;
    assign o_data  = r_o_data;

endmodule

### design/quaternion_to_transform_matrix_unit.sv
// ----------------------------------------------------------------------------
// quaternion_to_transform_matrix_unit: quaternion, scale, position to 4x4
// Top level; front stage, work queue and output sequencer.
// ----------------------------------------------------------------------------
// Each accepted word (quaternion Q1.14, scale Q8.8, position Q16.16) yields
// four output words, groups 0..3 of the row-major 4x4 matrix in Q16.16, with
// last set on group 3. The output sequencer emits one group per cycle while
// entries wait and the receiver is ready; a new input is taken while earlier
// ones are queued or draining. The product register loads at the accepting
// edge, and the first group then passes the queue write, the scale multiply
// register and the output register before it is valid. Up to QDEPTH processed
// inputs wait in the queue, letting input and output stall independently.
module quaternion_to_transform_matrix_unit import qtm_pkg::*; #(
    parameter int QDEPTH = QDEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_qtm_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_qtm_out o_data
);

    logic       fq_wr_en, fq_rd_en;
    t_fq_entry  fq_wr_data, fq_rd_data;
    t_fq_status fq_status;

    qtm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_data    (i_data),
        .o_ready   (o_ready),
        .i_fq_full (fq_status.full),
        .o_wr_en   (fq_wr_en),
        .o_wr_data (fq_wr_data)
    );

    qtm_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (fq_wr_en),
        .i_wr_data (fq_wr_data),
        .i_rd_en   (fq_rd_en),
        .o_rd_data (fq_rd_data),
        .o_status  (fq_status)
    );

    qtm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_data   (fq_rd_data),
        .i_fq_status (fq_status),
        .o_rd_en     (fq_rd_en),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fq_wr_en |-> !fq_status.full)
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fq_rd_en |-> !fq_status.empty)
        else $error("queue pop while empty");

    a_last_on_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last == (o_data.group_index == 2'(GRP_POS))))
        else $error("last flag does not match final group");

    a_pos_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.group_index == 2'(GRP_POS)) |->
        (!o_data.saturated && o_data.word3 == ONE_Q16))
        else $error("position row malformed");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: quaternion_to_transform_matrix_unit
// Drives quaternion/scale/position words through the unit, predicts the four
// Q16.16 matrix groups of each word, and checks every output word in order
// under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    import qtm_pkg::*;

    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     DRAIN_CYCLES   = 20;
    localparam int     MAX_REPORTS    = 100;
    localparam longint UNIT_Q28       = 64'sd1 <<< 28;
    localparam longint UNIT_Q16       = 64'sd1 <<< 16;
    localparam longint SHIFT_OUT      = 20;
    localparam longint WORD_HI        = 64'sd2147483647;
    localparam longint WORD_LO        = -64'sd2147483648;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_qtm_in  i_data;
    logic     o_valid;
    logic     i_ready;
    t_qtm_out o_data;

    t_qtm_out expected_groups[$];
    int       error_count;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_stall_pct;

    quaternion_to_transform_matrix_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // rotation basis times axis scale, Q.28 * Q8.8 -> Q16.16, floor then clip
    function automatic void predict_transform(input t_qtm_in w);
        longint   x, y, z, q;
        longint   xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint   basis[9];
        longint   scl[3];
        longint   mword[16];
        longint   v;
        bit       clip[4];
        t_qtm_out grp;
        x  = longint'($signed(w.quat_x));
        y  = longint'($signed(w.quat_y));
        z  = longint'($signed(w.quat_z));
        q  = longint'($signed(w.quat_w));
        scl[0] = longint'($signed(w.scale_x));
        scl[1] = longint'($signed(w.scale_y));
        scl[2] = longint'($signed(w.scale_z));
        xx = x * x;  yy = y * y;  zz = z * z;
        xy = x * y;  xz = x * z;  yz = y * z;
        wx = q * x;  wy = q * y;  wz = q * z;
        basis[0] = UNIT_Q28 - 2 * (yy + zz);
        basis[1] = 2 * (xy + wz);
        basis[2] = 2 * (xz - wy);
        basis[3] = 2 * (xy - wz);
        basis[4] = UNIT_Q28 - 2 * (xx + zz);
        basis[5] = 2 * (yz + wx);
        basis[6] = 2 * (xz + wy);
        basis[7] = 2 * (yz - wx);
        basis[8] = UNIT_Q28 - 2 * (xx + yy);
        clip = '{default: 1'b0};
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                v = (basis[3*r + k] * scl[r]) >>> SHIFT_OUT;
                if (v > WORD_HI) begin
                    v = WORD_HI;
                    clip[r] = 1'b1;
                end else if (v < WORD_LO) begin
                    v = WORD_LO;
                    clip[r] = 1'b1;
                end
                mword[4*r + k] = v;
            end
            mword[4*r + 3] = 0;
        end
        mword[12] = longint'($signed(w.pos_x));
        mword[13] = longint'($signed(w.pos_y));
        mword[14] = longint'($signed(w.pos_z));
        mword[15] = UNIT_Q16;
        for (int g = 0; g < 4; g++) begin
            grp.group_index = 2'(g);
            grp.word0       = 32'(mword[4*g]);
            grp.word1       = 32'(mword[4*g + 1]);
            grp.word2       = 32'(mword[4*g + 2]);
            grp.word3       = 32'(mword[4*g + 3]);
            grp.last        = (g == 3);
            grp.saturated   = clip[g];
            expected_groups.push_back(grp);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [1:0] grp,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("group %0d %s: got %h, expected %h",
                                      grp, name, got, want));
    endtask

    always @(posedge i_clk) begin : result_check
        t_qtm_out want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (expected_groups.size() == 0) begin
                report_mismatch("output word with nothing expected");
            end else begin
                want = expected_groups.pop_front();
                check_field("group_index", want.group_index,
                            32'(o_data.group_index), 32'(want.group_index));
                check_field("word0", want.group_index, o_data.word0, want.word0);
                check_field("word1", want.group_index, o_data.word1, want.word1);
                check_field("word2", want.group_index, o_data.word2, want.word2);
                check_field("word3", want.group_index, o_data.word3, want.word3);
                check_field("last", want.group_index,
                            32'(o_data.last), 32'(want.last));
                check_field("saturated", want.group_index,
                            32'(o_data.saturated), 32'(want.saturated));
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_word(input t_qtm_in w);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = w;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predict_transform(w);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_groups.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_qtm_in make_word(input int x, input int y, input int z,
                                          input int q, input int sx, input int sy,
                                          input int sz, input int px, input int py,
                                          input int pz);
        t_qtm_in w;
        w.quat_x  = 16'(x);
        w.quat_y  = 16'(y);
        w.quat_z  = 16'(z);
        w.quat_w  = 16'(q);
        w.scale_x = 16'(sx);
        w.scale_y = 16'(sy);
        w.scale_z = 16'(sz);
        w.pos_x   = 32'(px);
        w.pos_y   = 32'(py);
        w.pos_z   = 32'(pz);
        return w;
    endfunction

    // raw bit patterns, bounded quaternion and scale values, some pure translations
    function automatic t_qtm_in random_word();
        t_qtm_in w;
        int      mode;
        mode = $urandom_range(0, 9);
        w = make_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        if (mode >= 4 && mode < 8) begin
            w.quat_x  = 16'(int'($urandom_range(0, 32767)) - 16384);
            w.quat_y  = 16'(int'($urandom_range(0, 32767)) - 16384);
            w.quat_z  = 16'(int'($urandom_range(0, 32767)) - 16384);
            w.quat_w  = 16'(int'($urandom_range(0, 32767)) - 16384);
            w.scale_x = 16'(int'($urandom_range(0, 2047)) - 1024);
            w.scale_y = 16'(int'($urandom_range(0, 2047)) - 1024);
            w.scale_z = 16'(int'($urandom_range(0, 2047)) - 1024);
        end else if (mode >= 8) begin
            w.quat_x  = '0;
            w.quat_y  = '0;
            w.quat_z  = '0;
            w.quat_w  = 16'sd16384;
            w.scale_x = 16'sd256;
            w.scale_y = 16'sd256;
            w.scale_z = 16'sd256;
        end
        return w;
    endfunction

    task automatic send_random_burst(input int count);
        for (int n = 0; n < count; n++) send_word(random_word());
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // identity rotation, unit scale, no translation
        send_word(make_word(0, 0, 0, 16384, 256, 256, 256, 0, 0, 0));
        send_word(make_word(0, 0, 0, 16384, -256, -256, -256, 0, 0, 0));
        send_word(make_word(0, 0, 0, 16384, 32767, -32768, 1, 0, 0, 0));
        // quarter turns about each axis, then a half turn about x
        send_word(make_word(11585, 0, 0, 11585, 256, 256, 256, 65536, 0, 0));
        send_word(make_word(0, 11585, 0, 11585, 256, 256, 256, 0, 65536, 0));
        send_word(make_word(0, 0, 11585, 11585, 256, 256, 256, 0, 0, 65536));
        send_word(make_word(16384, 0, 0, 0, 256, 256, 256, 0, 0, 0));
        // component extremes, far from normalized
        send_word(make_word(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        send_word(make_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            32'h80000000, 32'h80000000, 32'h80000000));
        send_word(make_word(-32768, 32767, -32768, 32767, 32767, -32768, 32767,
                            -1, 1, 32'h80000000));
        send_word(make_word(32767, -32768, 32767, -32768, -32768, 32767, -32768,
                            32'h7fffffff, -1, 0));
        // tiny negative products: floor shift rounds toward minus infinity
        send_word(make_word(1, 0, 0, -1, 1, 1, 1, 0, 0, 0));
        send_word(make_word(-1, 1, -1, 1, -1, 1, -1, 0, 0, 0));
        send_word(make_word(0, 0, 0, 0, 1, -1, 32767, 0, 0, 0));
        send_word(make_word(23170, 23170, 23170, 23170, 256, 512, 128, 12345, -6789, 0));
        send_word(make_word(0, 0, 0, 0, -32768, -32768, -32768, 0, 0, 0));
        send_word(make_word(-32768, 0, 0, 0, 32767, 32767, 32767, 0, 0, 0));
        send_word(make_word(0, -32768, 0, 0, -32768, 32767, -32768, 0, 0, 0));
        send_word(make_word(0, 0, -32768, 32767, 32767, -32768, 32767, 0, 0, 0));
        wait_for_drain();
    endtask

    task automatic test_streaming_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_burst(50);
    endtask

    task automatic test_sender_idle();
        send_idle_pct  = 78;
        recv_stall_pct = 0;
        send_random_burst(35);
    endtask

    task automatic test_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        send_random_burst(35);
    endtask

    task automatic test_both_idle();
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        send_random_burst(45);
    endtask

    // sender holds off until the pipe is empty, then restarts at full rate
    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 11;
        send_random_burst(12);
        wait_for_drain();
        send_random_burst(12);
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data         = '0;
        i_ready        = 1'b0;
        error_count    = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_streaming_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_drain_pause();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
